@@ rtl/nrct_pkg.sv @@
// Shared types and constants for the receive completion tracker.
// No dependencies; used by nrct_classify and nic_rx_completion_tracker_core.
package nrct_pkg;

    // Field widths fixed by the descriptor and status formats
    localparam int unsigned STATUS_W    = 32;
    localparam int unsigned ERRORS_W    = 8;
    localparam int unsigned LENGTH_W    = 16;
    localparam int unsigned MAXLEN_W    = 14;
    localparam int unsigned RING_IDX_W  = 6;
    localparam int unsigned COUNT_W     = 32;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 14;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ADV_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN  = 2'd1;

    // Frame checks and status decode
    localparam logic [LENGTH_W-1:0] MIN_FRAME     = 16'd14;
    localparam logic [MAXLEN_W-1:0] MAX_LEN_RESET = 14'd1518;
    localparam logic [STATUS_W-1:0] FAIL_WORD     = 32'hffff_ffff;

    // Speed codes
    localparam logic [1:0] SPEED_10   = 2'd0;
    localparam logic [1:0] SPEED_100  = 2'd1;
    localparam logic [1:0] SPEED_1000 = 2'd2;
    localparam logic [1:0] SPEED_2500 = 2'd3;

    // Item kinds
    localparam logic CMD_DESC   = 1'b0;
    localparam logic CMD_STATUS = 1'b1;

    typedef enum logic [2:0] {
        ACT_NOT_READY = 3'd0,
        ACT_DROPPED   = 3'd1,
        ACT_ERROR     = 3'd2,
        ACT_DELIVER   = 3'd3,
        ACT_LINK      = 3'd4,
        ACT_FAILURE   = 3'd5
    } t_action;

    typedef struct packed {
        logic                cmd;
        logic [STATUS_W-1:0] desc_status;
        logic [ERRORS_W-1:0] desc_errors;
        logic [LENGTH_W-1:0] desc_length;
        logic [STATUS_W-1:0] status_word;
    } t_in_item;

    typedef struct packed {
        logic [2:0]            action;
        logic [RING_IDX_W-1:0] ring_index;
        logic [LENGTH_W-1:0]   frame_length;
        logic                  link_up;
        logic [1:0]            speed_code;
        logic [COUNT_W-1:0]    completed_total;
        logic [COUNT_W-1:0]    dropped_total;
        logic [COUNT_W-1:0]    error_total;
    } t_out_item;

    // Verdict of the classifier, consumed by the state update
    typedef struct packed {
        t_action    action;
        logic       consume;
        logic       discard_next;
        logic       link_upd;
        logic       link_next;
        logic [1:0] speed_next;
    } t_class;

endpackage

@@ rtl/nrct_classify.sv @@
// Combinational classifier: judges one descriptor or status word item.
// Depends on nrct_pkg.
module nrct_classify (
    input  nrct_pkg::t_in_item                i_item,
    input  logic                              i_advanced_mode,
    input  logic [nrct_pkg::MAXLEN_W-1:0]     i_max_frame_length,
    input  logic                              i_discard_flag,
    output nrct_pkg::t_class                  o_verdict
);

    logic [nrct_pkg::STATUS_W-1:0] status;
    logic                          eop;
    logic                          bad;
    logic                          len_bad;

    // Legacy format only carries the low status byte
    assign status  = i_advanced_mode ? i_item.desc_status
                                     : {24'd0, i_item.desc_status[7:0]};
    assign eop     = status[1];
    assign bad     = i_advanced_mode ? (|status[31:24]) : (|i_item.desc_errors);
    assign len_bad = (i_item.desc_length < nrct_pkg::MIN_FRAME) ||
                     (i_item.desc_length > {2'd0, i_max_frame_length});

    always_comb begin
        o_verdict              = '0;
        o_verdict.action       = nrct_pkg::ACT_NOT_READY;
        o_verdict.discard_next = i_discard_flag;
        o_verdict.speed_next   = nrct_pkg::SPEED_10;
        if (i_item.cmd == nrct_pkg::CMD_DESC) begin
            if (status[0]) begin
                o_verdict.consume = 1'b1;
                if (!eop || i_discard_flag) begin
                    // Multi-descriptor frame or tail of one: dropped
                    o_verdict.action       = nrct_pkg::ACT_DROPPED;
                    o_verdict.discard_next = !eop;
                end else if (bad || len_bad) begin
                    o_verdict.action = nrct_pkg::ACT_ERROR;
                end else begin
                    o_verdict.action = nrct_pkg::ACT_DELIVER;
                end
            end
        end else begin
            if (i_item.status_word == nrct_pkg::FAIL_WORD) begin
                // Device gone from the bus: leave link state alone
                o_verdict.action = nrct_pkg::ACT_FAILURE;
            end else begin
                o_verdict.action    = nrct_pkg::ACT_LINK;
                o_verdict.link_upd  = 1'b1;
                o_verdict.link_next = i_item.status_word[1];
                if (i_advanced_mode && i_item.status_word[22]) begin
                    o_verdict.speed_next = nrct_pkg::SPEED_2500;
                end else if (i_item.status_word[7]) begin
                    o_verdict.speed_next = nrct_pkg::SPEED_1000;
                end else if (i_item.status_word[6]) begin
                    o_verdict.speed_next = nrct_pkg::SPEED_100;
                end else begin
                    o_verdict.speed_next = nrct_pkg::SPEED_10;
                end
            end
        end
    end

endmodule

@@ rtl/nic_rx_completion_tracker_core.sv @@
// Receive completion tracker top level: input register, classifier, state, result register.
// Depends on nrct_pkg and nrct_classify.
// Throughput: one item per cycle; output backpressure stalls the result and input registers.
// Reset (synchronous, active low) clears head, discard flag, counters, link state,
// configuration to its defaults and both valid flags; no clearing pass.
module nic_rx_completion_tracker_core #(
    parameter int unsigned RING_DEPTH = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  nrct_pkg::t_in_item                i_in_item,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output nrct_pkg::t_out_item               o_out_item,
    input  logic                              i_cfg_we,
    input  logic [nrct_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [nrct_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int unsigned HEAD_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam logic [HEAD_W-1:0] HEAD_LAST = HEAD_W'(RING_DEPTH - 1);

    // Configuration
    logic                          r_adv_mode;
    logic [nrct_pkg::MAXLEN_W-1:0] r_max_len;

    // Pipeline registers
    logic                r_in_valid;
    nrct_pkg::t_in_item  r_in_item;
    logic                r_out_valid;
    nrct_pkg::t_out_item r_out_item;

    // Tracker state
    logic [HEAD_W-1:0]            r_head;
    logic                         r_discard;
    logic [nrct_pkg::COUNT_W-1:0] r_completed;
    logic [nrct_pkg::COUNT_W-1:0] r_dropped;
    logic [nrct_pkg::COUNT_W-1:0] r_errors;
    logic                         r_link;
    logic [1:0]                   r_speed;

    logic [HEAD_W-1:0]            n_head;
    logic [nrct_pkg::COUNT_W-1:0] n_completed;
    logic [nrct_pkg::COUNT_W-1:0] n_dropped;
    logic [nrct_pkg::COUNT_W-1:0] n_errors;
    logic                         n_link;
    logic [1:0]                   n_speed;
    nrct_pkg::t_out_item          n_out_item;

    nrct_pkg::t_class             cls;
    logic                         out_free;
    logic                         s1_fire;
    logic [HEAD_W+nrct_pkg::RING_IDX_W-1:0] head_wide;

    // Handshake: registers advance once the result slot frees; input also when it is empty
    assign out_free    = !r_out_valid || i_out_ready;
    assign s1_fire     = r_in_valid && out_free;
    assign o_in_ready  = !r_in_valid || out_free;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adv_mode <= 1'b0;
            r_max_len  <= nrct_pkg::MAX_LEN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                nrct_pkg::CFG_ADV_MODE: r_adv_mode <= i_cfg_data[0];
                nrct_pkg::CFG_MAX_LEN:  r_max_len  <= i_cfg_data[nrct_pkg::MAXLEN_W-1:0];
                default: ;
            endcase
        end
    end

    nrct_classify u_classify (
        .i_item             (r_in_item),
        .i_advanced_mode    (r_adv_mode),
        .i_max_frame_length (r_max_len),
        .i_discard_flag     (r_discard),
        .o_verdict          (cls)
    );

    // Next state and result from the classifier verdict
    assign head_wide = {{nrct_pkg::RING_IDX_W{1'b0}}, r_head};

    always_comb begin
        n_head      = r_head;
        n_completed = r_completed;
        n_dropped   = r_dropped;
        n_errors    = r_errors;
        n_link      = r_link;
        n_speed     = r_speed;
        if (cls.consume) begin
            n_head      = (r_head == HEAD_LAST) ? '0 : r_head + 1'b1;
            n_completed = r_completed + 1'b1;
        end
        if (cls.action == nrct_pkg::ACT_DROPPED) begin
            n_dropped = r_dropped + 1'b1;
        end
        if (cls.action == nrct_pkg::ACT_ERROR) begin
            n_errors = r_errors + 1'b1;
        end
        if (cls.link_upd) begin
            n_link  = cls.link_next;
            n_speed = cls.speed_next;
        end

        n_out_item                 = '0;
        n_out_item.action          = cls.action;
        n_out_item.ring_index      = head_wide[nrct_pkg::RING_IDX_W-1:0];
        n_out_item.frame_length    = cls.consume ? r_in_item.desc_length : '0;
        n_out_item.link_up         = n_link;
        n_out_item.speed_code      = n_speed;
        n_out_item.completed_total = n_completed;
        n_out_item.dropped_total   = n_dropped;
        n_out_item.error_total     = n_errors;
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    // State update and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_head      <= '0;
            r_discard   <= 1'b0;
            r_completed <= '0;
            r_dropped   <= '0;
            r_errors    <= '0;
            r_link      <= 1'b0;
            r_speed     <= nrct_pkg::SPEED_10;
        end else begin
            if (s1_fire) begin
                r_out_valid <= 1'b1;
                r_head      <= n_head;
                r_discard   <= cls.discard_next;
                r_completed <= n_completed;
                r_dropped   <= n_dropped;
                r_errors    <= n_errors;
                r_link      <= n_link;
                r_speed     <= n_speed;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_item <= n_out_item;
        end
    end

    // Checks on the tracker state
    a_head_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && !cls.consume) |=> $stable(r_head) && $stable(r_completed))
        else $error("ring head or completed count moved on an unconsumed item");

    a_completed_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && cls.consume) |=> r_completed == $past(r_completed) + 1'b1)
        else $error("completed count did not step on a consumed descriptor");

    a_drop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && cls.action != nrct_pkg::ACT_DROPPED) |=> $stable(r_dropped))
        else $error("dropped count moved without a drop");

    a_fail_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && cls.action == nrct_pkg::ACT_FAILURE) |=> $stable(r_link) && $stable(r_speed))
        else $error("link state changed on device failure");

    a_stall_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s1_fire |=> $stable(r_head) && $stable(r_discard) && $stable(r_errors))
        else $error("tracker state changed while stalled");

endmodule
